@@ sv/gdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

	// Field widths.
	localparam int DN_W   = 23;
	localparam int YEAR_W = 14;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;

	// Stream payload widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	// Pipeline stages from the input register to the output register.
	localparam int NSTG = 8;

	// Calendar constants.
	localparam int unsigned EPOCH_DAY  = 1721425;
	localparam int unsigned MAX_YEAR   = 9999;
	localparam int unsigned DAYS_400Y  = 146097;
	localparam int unsigned DAYS_100Y  = 36524;
	localparam int unsigned DAYS_4Y    = 1461;
	localparam int unsigned DAYS_1Y    = 365;
	localparam int unsigned MAX_LEAP   = ((MAX_YEAR % 4 == 0) &&
		((MAX_YEAR % 100 != 0) || (MAX_YEAR % 400 == 0))) ? 1 : 0;
	// Day number of 31 December of the last supported year.
	localparam int unsigned LAST_DAY   = EPOCH_DAY - 1 + DAYS_1Y * (MAX_YEAR - 1)
		+ (MAX_YEAR - 1) / 4 - (MAX_YEAR - 1) / 100 + (MAX_YEAR - 1) / 400
		+ DAYS_1Y + MAX_LEAP;

	// Internal datapath widths.
	localparam int E_W    = 22;  // day offset from the epoch
	localparam int Q_W    = 5;   // 400-year periods
	localparam int RQ_W   = 18;  // days within a 400-year period
	localparam int C_W    = 3;   // centuries within a period, 0..4
	localparam int RC_W   = 16;  // days within a century
	localparam int F_W    = 5;   // 4-year groups within a century
	localparam int RF_W   = 11;  // days within a 4-year group
	localparam int YI_W   = 3;   // years within a 4-year group, 0..4
	localparam int YDAY_W = 9;   // day of year, 0..365
	localparam int Q100_W = 8;   // centuries in a year count

	// Reciprocal multipliers for the constant divisions. Each shift is chosen so
	// that the rounded-up reciprocal is exact over the whole operand range.
	localparam int unsigned   Q400_SH = 40;
	localparam longint unsigned K400  = ((64'd1 << Q400_SH) + DAYS_400Y - 1) / DAYS_400Y;
	localparam int            K400_W  = 23;
	localparam int            Q400_PW = E_W + K400_W;

	localparam int unsigned   Q4_SH   = 27;
	localparam longint unsigned K4    = ((64'd1 << Q4_SH) + DAYS_4Y - 1) / DAYS_4Y;
	localparam int            K4_W    = 17;
	localparam int            Q4_PW   = RC_W + K4_W;

	localparam int unsigned   Q25_SH  = 17;
	localparam longint unsigned K25   = ((64'd1 << Q25_SH) + 25 - 1) / 25;
	localparam int            K25_W   = 13;
	localparam int            Q25_PW  = YEAR_W - 2 + K25_W;

	typedef enum logic {
		CMD_TO_DAYS = 1'b0,
		CMD_TO_DATE = 1'b1
	} gdc_cmd_t;

	// Load enables of the shared pipeline stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} gdc_ld_t;

	typedef struct packed {
		logic              bad;
		logic [DN_W-1:0]   dn;
	} gdc_dn_t;

	typedef struct packed {
		logic              bad;
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
	} gdc_date_t;

	// Days in the year before the first of month m, counting February as 30 days.
	function automatic logic [YDAY_W-1:0] month_start(input logic [MON_W-1:0] m);
		logic [YDAY_W-1:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd61;
			4'd4:    r = 9'd92;
			4'd5:    r = 9'd122;
			4'd6:    r = 9'd153;
			4'd7:    r = 9'd183;
			4'd8:    r = 9'd214;
			4'd9:    r = 9'd245;
			4'd10:   r = 9'd275;
			4'd11:   r = 9'd306;
			4'd12:   r = 9'd336;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// The start table above assumes a 30-day February; from March on the
	// real offset is one day less in a leap year and two in a common year.
	function automatic logic [1:0] month_corr(input logic [MON_W-1:0] m, input logic leap);
		logic [1:0] r;
		if (m > MON_W'(2)) begin
			r = leap ? 2'd1 : 2'd2;
		end else begin
			r = 2'd0;
		end
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = leap ? 5'd29 : 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	// Month from the adjusted day of year x: (12 x + 373) / 367, limited to
	// 1..12, done as a row of compares against constant thresholds.
	function automatic logic [MON_W-1:0] month_of(input logic [YDAY_W-1:0] x);
		logic [12:0]      v;
		logic [MON_W-1:0] mo;
		v  = 13'(x) * 13'd12 + 13'd373;
		mo = MON_W'(1);
		for (int k = 2; k <= 12; k++) begin
			if (v >= 13'(367 * k)) begin
				mo = mo + MON_W'(1);
			end
		end
		return mo;
	endfunction

endpackage

`default_nettype wire

@@ sv/gdc_to_days.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdc_to_days (
	input  wire logic                     clk,
	input  wire gdc_pkg::gdc_ld_t         ld,
	input  wire logic [gdc_pkg::YEAR_W-1:0] year,
	input  wire logic [gdc_pkg::MON_W-1:0]  month,
	input  wire logic [gdc_pkg::DAY_W-1:0]  day,
	output gdc_pkg::gdc_dn_t              result
);
	import gdc_pkg::*;

	logic [YEAR_W-1:0] p;
	logic [Q25_PW-1:0] p_prod;
	logic [Q100_W-1:0] q100;
	logic              ok;

	logic [YEAR_W-1:0] p_s2;
	logic [Q100_W-1:0] q100_s2;
	logic [1:0]        ylo_s2;
	logic [MON_W-1:0]  month_s2;
	logic [DAY_W-1:0]  day_s2;
	logic              ok_s2;

	logic [6:0]        r100;
	logic              leap;
	logic [DN_W-1:0]   base;

	logic [DN_W-1:0]   base_s3;
	logic              leap_s3;
	logic [MON_W-1:0]  month_s3;
	logic [DAY_W-1:0]  day_s3;
	logic              ok_s3;

	// Whole years before the date and the number of centuries among them.
	assign p      = year - YEAR_W'(1);
	assign p_prod = Q25_PW'(p[YEAR_W-1:2]) * Q25_PW'(K25);
	assign q100   = p_prod[Q25_SH +: Q100_W];
	assign ok     = (year >= YEAR_W'(1)) && (year <= YEAR_W'(MAX_YEAR)) &&
		(month >= MON_W'(1)) && (month <= MON_W'(12)) && (day >= DAY_W'(1));

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			p_s2     <= p;
			q100_s2  <= q100;
			ylo_s2   <= year[1:0];
			month_s2 <= month;
			day_s2   <= day;
			ok_s2    <= ok;
		end
	end

	// A year divisible by 100 has p mod 100 equal to 99; by 400 also needs the
	// century count to end in binary 11.
	assign r100 = 7'(p_s2 - YEAR_W'(q100_s2) * YEAR_W'(100));
	assign leap = (ylo_s2 == 2'b00) && ((r100 != 7'd99) || (q100_s2[1:0] == 2'b11));
	assign base = DN_W'(EPOCH_DAY - 1) + DN_W'(p_s2) * DN_W'(DAYS_1Y)
		+ DN_W'(p_s2[YEAR_W-1:2]) - DN_W'(q100_s2) + DN_W'(q100_s2[Q100_W-1:2]);

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			base_s3  <= base;
			leap_s3  <= leap;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
			ok_s3    <= ok_s2;
		end
	end

	assign result.bad = !ok_s3 || (day_s3 > month_len(month_s3, leap_s3));
	assign result.dn  = base_s3 + DN_W'(month_start(month_s3)) + DN_W'(day_s3)
		- DN_W'(month_corr(month_s3, leap_s3));

endmodule

`default_nettype wire

@@ sv/gdc_from_days.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdc_from_days (
	input  wire logic                   clk,
	input  wire gdc_pkg::gdc_ld_t       ld,
	input  wire logic [gdc_pkg::DN_W-1:0] day_number,
	output gdc_pkg::gdc_date_t          result
);
	import gdc_pkg::*;

	logic [DN_W-1:0]    off;
	logic [E_W-1:0]     e;
	logic [Q400_PW-1:0] e_prod;
	logic [Q_W-1:0]     q;
	logic               range_bad;

	logic [E_W-1:0]     e_s2;
	logic [Q_W-1:0]     q_s2;
	logic               bad_s2;

	logic [RQ_W-1:0]    rq;
	logic [RQ_W-1:0]    rq_s3;
	logic [Q_W-1:0]     q_s3;
	logic               bad_s3;

	logic [C_W-1:0]     c;
	logic [RC_W-1:0]    rc;
	logic [RC_W-1:0]    rc_s4;
	logic [C_W-1:0]     c_s4;
	logic [Q_W-1:0]     q_s4;
	logic               bad_s4;

	logic [Q4_PW-1:0]   rc_prod;
	logic [F_W-1:0]     f;
	logic [RC_W-1:0]    rc_s5;
	logic [F_W-1:0]     f_s5;
	logic [C_W-1:0]     c_s5;
	logic [Q_W-1:0]     q_s5;
	logic               bad_s5;

	logic [RF_W-1:0]    rf;
	logic [YI_W-1:0]    yi;
	logic               last_day;
	logic               leap;
	logic [YEAR_W-1:0]  yr;
	logic [YEAR_W-1:0]  yr_s6;
	logic               leap_s6;
	logic               last_day_s6;
	logic [RF_W-1:0]    rf_s6;
	logic [YI_W-1:0]    yi_s6;
	logic               bad_s6;

	logic [YDAY_W-1:0]  yday;
	logic [YDAY_W-1:0]  xday;
	logic               before_mar;
	logic [YEAR_W-1:0]  yr_s7;
	logic               leap_s7;
	logic [YDAY_W-1:0]  yday_s7;
	logic [YDAY_W-1:0]  xday_s7;
	logic               bad_s7;

	logic [MON_W-1:0]   mo;

	// Offset from the epoch and its count of 400-year periods.
	assign off       = day_number - DN_W'(EPOCH_DAY);
	assign e         = off[E_W-1:0];
	assign range_bad = (day_number < DN_W'(EPOCH_DAY)) || (day_number > DN_W'(LAST_DAY));
	assign e_prod    = Q400_PW'(e) * Q400_PW'(K400);
	assign q         = e_prod[Q400_SH +: Q_W];

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			e_s2   <= e;
			q_s2   <= q;
			bad_s2 <= range_bad;
		end
	end

	assign rq = RQ_W'(e_s2 - E_W'(q_s2) * E_W'(DAYS_400Y));

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			rq_s3  <= rq;
			q_s3   <= q_s2;
			bad_s3 <= bad_s2;
		end
	end

	// Centuries: the count reaches four only on the last day of a period.
	always_comb begin
		c = '0;
		for (int k = 1; k <= 4; k++) begin
			if (rq_s3 >= RQ_W'(k * DAYS_100Y)) begin
				c = c + C_W'(1);
			end
		end
	end
	assign rc = RC_W'(rq_s3 - RQ_W'(c) * RQ_W'(DAYS_100Y));

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			rc_s4  <= rc;
			c_s4   <= c;
			q_s4   <= q_s3;
			bad_s4 <= bad_s3;
		end
	end

	assign rc_prod = Q4_PW'(rc_s4) * Q4_PW'(K4);
	assign f       = rc_prod[Q4_SH +: F_W];

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			rc_s5  <= rc_s4;
			f_s5   <= f;
			c_s5   <= c_s4;
			q_s5   <= q_s4;
			bad_s5 <= bad_s4;
		end
	end

	assign rf = RF_W'(rc_s5 - RC_W'(f_s5) * RC_W'(DAYS_4Y));

	always_comb begin
		yi = '0;
		for (int k = 1; k <= 4; k++) begin
			if (rf >= RF_W'(k * DAYS_1Y)) begin
				yi = yi + YI_W'(1);
			end
		end
	end

	// A count of four centuries or four years marks 31 December of a leap
	// year; the year count then already names that year. Otherwise the year
	// is leap when it is the fourth of its group, unless that group closes a
	// century other than the last of the period.
	assign last_day = (c_s5 == 3'd4) || (yi == 3'd4);
	assign leap     = last_day || ((yi == 3'd3) && ((f_s5 != 5'd24) || (c_s5 == 3'd3)));
	assign yr       = YEAR_W'(400) * YEAR_W'(q_s5) + YEAR_W'(100) * YEAR_W'(c_s5)
		+ YEAR_W'({f_s5, 2'b00}) + YEAR_W'(yi) + YEAR_W'(!last_day);

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			yr_s6       <= yr;
			leap_s6     <= leap;
			last_day_s6 <= last_day;
			rf_s6       <= rf;
			yi_s6       <= yi;
			bad_s6      <= bad_s5;
		end
	end

	assign yday       = last_day_s6 ? YDAY_W'(DAYS_1Y)
		: YDAY_W'(rf_s6 - RF_W'(yi_s6) * RF_W'(DAYS_1Y));
	assign before_mar = yday < (leap_s6 ? YDAY_W'(60) : YDAY_W'(59));
	assign xday       = before_mar ? yday
		: yday + (leap_s6 ? YDAY_W'(1) : YDAY_W'(2));

	always_ff @(posedge clk) begin
		if (ld.s7) begin
			yr_s7   <= yr_s6;
			leap_s7 <= leap_s6;
			yday_s7 <= yday;
			xday_s7 <= xday;
			bad_s7  <= bad_s6;
		end
	end

	assign mo           = month_of(xday_s7);
	assign result.bad   = bad_s7;
	assign result.year  = yr_s7;
	assign result.month = mo;
	assign result.day   = DAY_W'(yday_s7 - month_start(mo)
		+ YDAY_W'(month_corr(mo, leap_s7)) + YDAY_W'(1));

endmodule

`default_nettype wire

@@ sv/gregorian_day_number_converter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date / day number converter.
// The input stream carries one command per item. With tuser low the item holds
// a date (year, month, day) and the result is its whole day number, the floor
// of the Julian date minus one half. With tuser high the item holds a day
// number and the result is the proleptic Gregorian year, month and day.
// Every item gives exactly one result item. An operand outside 1 January of
// year 1 to 31 December of the last supported year, or a date that does not
// exist, returns all fields zero with the invalid flag in m_tuser set.
// The datapath is an eight-stage pipeline, one constant division or one
// compare-and-subtract per stage. Items go in order from s1 to the output
// register s8; one is accepted every cycle unless the full pipeline stalls.
// Each stage holds its item until the next stage frees up, so a stalled
// receiver fills the bubbles in the pipeline first, and s_tready falls only
// when all eight stages hold items. The output stage is a plain register.
// Reset empties the pipeline; the unit keeps no state between items.
module gregorian_day_number_converter_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// in_year [13:0], in_month [17:14], in_day [22:18], in_day_number [45:23]
	input  wire logic [gdc_pkg::S_TDATA_W-1:0] s_tdata,
	// command
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// out_day_number [22:0], out_year [36:23], out_month [40:37], out_day [45:41]
	output logic [gdc_pkg::M_TDATA_W-1:0]      m_tdata,
	// invalid
	output logic                               m_tuser
);
	import gdc_pkg::*;

	// Stage occupancy and per-stage ready. A stage takes a new item when it
	// is empty or its own item moves on in the same cycle.
	logic [NSTG:1] vld_q;
	logic [NSTG:1] rdy;
	gdc_ld_t       ld;

	// Stage one: the accepted item.
	gdc_cmd_t          cmd_s1;
	logic [YEAR_W-1:0] year_s1;
	logic [MON_W-1:0]  month_s1;
	logic [DAY_W-1:0]  day_s1;
	logic [DN_W-1:0]   dn_s1;

	gdc_cmd_t cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7;
	gdc_dn_t  days_res;
	gdc_dn_t  days_s4, days_s5, days_s6, days_s7;
	gdc_date_t date_res;

	// Output stage.
	logic [DN_W-1:0]   out_dn;
	logic [YEAR_W-1:0] out_year;
	logic [MON_W-1:0]  out_month;
	logic [DAY_W-1:0]  out_day;
	logic              out_bad;
	logic [DN_W-1:0]   out_dn_s8;
	logic [YEAR_W-1:0] out_year_s8;
	logic [MON_W-1:0]  out_month_s8;
	logic [DAY_W-1:0]  out_day_s8;
	logic              out_bad_s8;

	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ld.s2 = rdy[2];
	assign ld.s3 = rdy[3];
	assign ld.s4 = rdy[4];
	assign ld.s5 = rdy[5];
	assign ld.s6 = rdy[6];
	assign ld.s7 = rdy[7];

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			cmd_s1   <= gdc_cmd_t'(s_tuser);
			year_s1  <= s_tdata[13:0];
			month_s1 <= s_tdata[17:14];
			day_s1   <= s_tdata[22:18];
			dn_s1    <= s_tdata[45:23];
		end
		if (rdy[2]) begin
			cmd_s2 <= cmd_s1;
		end
		if (rdy[3]) begin
			cmd_s3 <= cmd_s2;
		end
		if (rdy[4]) begin
			cmd_s4  <= cmd_s3;
			days_s4 <= days_res;
		end
		if (rdy[5]) begin
			cmd_s5  <= cmd_s4;
			days_s5 <= days_s4;
		end
		if (rdy[6]) begin
			cmd_s6  <= cmd_s5;
			days_s6 <= days_s5;
		end
		if (rdy[7]) begin
			cmd_s7  <= cmd_s6;
			days_s7 <= days_s6;
		end
		if (rdy[8]) begin
			out_dn_s8    <= out_dn;
			out_year_s8  <= out_year;
			out_month_s8 <= out_month;
			out_day_s8   <= out_day;
			out_bad_s8   <= out_bad;
		end
	end

	// Date to day number: finishes in stage three and rides along after that.
	gdc_to_days u_to_days (
		.clk    (clk),
		.ld     (ld),
		.year   (year_s1),
		.month  (month_s1),
		.day    (day_s1),
		.result (days_res)
	);

	// Day number to date: runs through stage seven.
	gdc_from_days u_from_days (
		.clk        (clk),
		.ld         (ld),
		.day_number (dn_s1),
		.result     (date_res)
	);

	// Pick the result of the item's command; fields that do not belong to the
	// command, and all fields of an invalid operand, read as zero.
	always_comb begin
		out_dn    = '0;
		out_year  = '0;
		out_month = '0;
		out_day   = '0;
		out_bad   = 1'b0;
		unique case (cmd_s7)
			CMD_TO_DAYS: begin
				out_bad = days_s7.bad;
				if (!days_s7.bad) begin
					out_dn = days_s7.dn;
				end
			end
			CMD_TO_DATE: begin
				out_bad = date_res.bad;
				if (!date_res.bad) begin
					out_year  = date_res.year;
					out_month = date_res.month;
					out_day   = date_res.day;
				end
			end
		endcase
	end

	assign m_tdata = {2'b00, out_day_s8, out_month_s8, out_year_s8, out_dn_s8};
	assign m_tuser = out_bad_s8;

endmodule

`default_nettype wire
